/* hw/rtl/base32_stream_encoder_defines.svh */
// Assertion macros for the base32 stream encoder.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BASE32_STREAM_ENCODER_DEFINES_SVH
`define BASE32_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define B32_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define B32_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/b32_pkg.sv */
// Shared types, constants and the alphabet function of the base32 encoder.
// No dependencies.
`default_nettype none

package b32_pkg;

	localparam int unsigned B32_QUEUE_DEPTH = 2;
	localparam logic [15:0] MAX_CHARS_RESET = 16'd256;

	localparam logic [6:0] CHAR_A      = 7'h41;
	localparam logic [6:0] CHAR_TWO    = 7'h32;
	localparam logic [4:0] NUM_LETTERS = 5'd26;

	// One classified item: up to three alphabet indices and how to emit them
	typedef struct packed {
		logic [2:0][4:0] idx;
		logic [1:0]      num;      // results for this item, 1..3
		logic            any;      // 0: single empty result
		logic            last;
	} b32_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b32_qstat_t;

	function automatic logic [6:0] b32_char(input logic [4:0] idx);
		logic [6:0] c;
		if (idx < NUM_LETTERS) begin
			c = CHAR_A + {2'b00, idx};
		end else begin
			c = CHAR_TWO + {2'b00, idx - NUM_LETTERS};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/b32_front.sv */
// Front end: accepts bytes, splits the bit accumulator into 5-bit groups,
// applies the per-message limit and pushes one job per item. Uses b32_pkg.
`default_nettype none

module b32_front import b32_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire b32_qstat_t  q_stat,
	output logic             q_push,
	output b32_job_t         q_job
);

	logic [15:0] max_chars_q;
	logic [3:0]  lbits_q;
	logic [2:0]  lcount_q;
	logic [15:0] emitted_q;

	logic [11:0] acc;
	logic [3:0]  nbits;
	logic        two;
	logic [2:0]  rem;
	logic [4:0]  low_mask;
	logic [4:0]  keep;
	logic [4:0]  idx0, idx1, idx_fl;
	logic        flush;
	logic [1:0]  ncand;
	logic [15:0] diff;
	logic [1:0]  avail;
	logic [1:0]  nemit;

	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		acc      = {lbits_q, data_byte};
		nbits    = {1'b0, lcount_q} + 4'd8;
		two      = (nbits >= 4'd10);
		idx0     = 5'(acc >> (nbits - 4'd5));
		idx1     = two ? 5'(acc >> (nbits - 4'd10)) : 5'd0;
		rem      = two ? 3'(nbits - 4'd10) : 3'(nbits - 4'd5);
		low_mask = 5'((5'd1 << rem) - 5'd1);
		keep     = {1'b0, acc[3:0]} & low_mask;
		idx_fl   = 5'(keep << (3'd5 - rem));
		flush    = last_byte && (rem != 3'd0);
		ncand    = (two ? 2'd2 : 2'd1) + {1'b0, flush};

		// room left under the limit, clamped to three
		diff = (max_chars_q > emitted_q) ? (max_chars_q - emitted_q) : 16'd0;
		avail = (diff >= 16'd3) ? 2'd3 : diff[1:0];
		nemit = (ncand < avail) ? ncand : avail;

		q_job.idx[0] = idx0;
		q_job.idx[1] = two ? idx1 : idx_fl;
		q_job.idx[2] = idx_fl;
		q_job.num    = (nemit == 2'd0) ? 2'd1 : nemit;
		q_job.any    = (nemit != 2'd0);
		q_job.last   = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RESET;
			lbits_q     <= 4'd0;
			lcount_q    <= 3'd0;
			emitted_q   <= 16'd0;
		end else begin
			if (cfg_valid) begin
				max_chars_q <= cfg_data;
			end
			if (q_push) begin
				if (last_byte) begin
					lbits_q   <= 4'd0;
					lcount_q  <= 3'd0;
					emitted_q <= 16'd0;
				end else begin
					lbits_q   <= keep[3:0];
					lcount_q  <= rem;
					emitted_q <= emitted_q + {14'd0, nemit};
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/b32_queue.sv */
// Short job queue between front and back end, register based.
// Uses b32_pkg for the job and status types.
`default_nettype none

module b32_queue import b32_pkg::*; #(
	parameter int unsigned DEPTH = B32_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire b32_job_t   push_job,
	input  wire logic       pop,
	output b32_job_t        head_job,
	output b32_qstat_t      stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	b32_job_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_job   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/b32_back.sv */
// Back end: walks the head job one result per cycle, unless out_ready stalls it, into the output register.
// Uses b32_pkg for the job type and the alphabet function.
`default_nettype none

module b32_back import b32_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire b32_job_t   head_job,
	input  wire b32_qstat_t q_stat,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      code_char,
	output logic            char_valid,
	output logic            item_done,
	output logic            message_end
);

	logic [1:0] pos_q;
	logic       out_valid_q;
	logic [6:0] code_q;
	logic       cvalid_q, done_q, mend_q;

	logic       advance;
	logic       is_end;
	logic [4:0] cur_idx;

	assign advance = (!out_valid_q || out_ready) && !q_stat.empty;
	assign is_end  = (pos_q == head_job.num - 2'd1);
	assign cur_idx = head_job.idx[pos_q];
	assign q_pop   = advance && is_end;

	assign out_valid   = out_valid_q;
	assign code_char   = code_q;
	assign char_valid  = cvalid_q;
	assign item_done   = done_q;
	assign message_end = mend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			out_valid_q <= 1'b0;
			code_q      <= 7'd0;
			cvalid_q    <= 1'b0;
			done_q      <= 1'b0;
			mend_q      <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				code_q      <= head_job.any ? b32_char(cur_idx) : 7'd0;
				cvalid_q    <= head_job.any;
				done_q      <= is_end;
				mend_q      <= is_end && head_job.last;
				pos_q       <= is_end ? 2'd0 : pos_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/base32_stream_encoder.sv */
// Unpadded base32 stream encoder (standard alphabet A-Z, 2-7). One byte
// enters per item together with a last flag; each byte gives one to three
// result items, one per character, the last of them marked item_done, and
// the final one of a message also message_end. On the last byte the
// remaining bits are zero-filled to five and emitted, and the encoder
// clears for the next message. max_chars (reset 256) caps the characters
// per message; an item whose characters are all cut gives one result with
// char_valid low and code_char zero. The front end takes a byte every cycle
// while the job queue has room; the back end drains one result per cycle,
// unless out_ready stalls it, into the single output register. max_chars
// may only be written while the encoder is idle; cfg_ready is always high.
`default_nettype none

`include "base32_stream_encoder_defines.svh"

module base32_stream_encoder import b32_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = B32_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	// character output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       code_char,
	output logic             char_valid,
	output logic             item_done,
	output logic             message_end
);

	b32_job_t   push_job, head_job;
	b32_qstat_t q_stat;
	logic       q_push, q_pop;

	assign cfg_ready = 1'b1;

	// classify bytes into jobs
	b32_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	// decouples the byte side from the character side
	b32_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	// one result item per cycle unless the output stalls
	b32_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_char   (code_char),
		.char_valid  (char_valid),
		.item_done   (item_done),
		.message_end (message_end)
	);

	// checks
	`B32_ASSERT_NOW(a_pop_has_data, q_pop, !q_stat.empty, "pop from empty job queue")
	`B32_ASSERT_NEXT(a_full_blocks, q_stat.full && !q_pop, !in_ready, "input taken into full queue")
	`B32_ASSERT_NOW(a_drop_is_zero, out_valid && !char_valid, code_char == 7'd0 && item_done, "empty result malformed")
	`B32_ASSERT_NOW(a_end_is_done, out_valid && message_end, item_done, "message end without item done")

endmodule

`default_nettype wire
